FILE: src/proot_pkg.sv
// Shared constants for the pre-trade risk open-order table.
// Holds default sizes, field widths, action and verdict codes; no dependencies.
package proot_pkg;

  // Default table sizes.
  localparam int SLOT_COUNT_DEF = 256;
  localparam int INST_COUNT_DEF = 64;

  // Fixed field widths.
  localparam int ID_W    = 32;
  localparam int INST_W  = 16;
  localparam int PRICE_W = 32;
  localparam int VOL_W   = 31;
  localparam int REM_W   = 33;

  // Action codes of an input word.
  localparam logic [2:0] ACT_CHECK_ORDER = 3'd0;
  localparam logic [2:0] ACT_CHECK_QUOTE = 3'd1;
  localparam logic [2:0] ACT_ACK         = 3'd2;
  localparam logic [2:0] ACT_FILL        = 3'd3;
  localparam logic [2:0] ACT_CANCEL      = 3'd4;

  // Verdict codes of a result word.
  localparam logic [1:0] VERDICT_OK        = 2'd0;
  localparam logic [1:0] VERDICT_MAX_VOL   = 2'd1;
  localparam logic [1:0] VERDICT_TOO_MANY  = 2'd2;
  localparam logic [1:0] VERDICT_SELF_TRADE = 2'd3;

endpackage

FILE: src/pretrade_risk_open_order_table.sv
// Fills, cancels and acks walk the slot memory for the id (an ack with a zero id or
// an instrument out of range does not), and removing a best price adds a slot rescan.
// One word is worked at a time: the input stalls until the result is registered.
// After reset a clearing pass over max(SLOT_COUNT, INSTRUMENT_COUNT) entries
// initialises the memories; no input word is taken during it.
module pretrade_risk_open_order_table #(
  parameter int SLOT_COUNT       = proot_pkg::SLOT_COUNT_DEF,
  parameter int INSTRUMENT_COUNT = proot_pkg::INST_COUNT_DEF,
  localparam int CW = $clog2(SLOT_COUNT + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [proot_pkg::VOL_W-1:0]          cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [2:0]                           in_action,
  input  logic [proot_pkg::ID_W-1:0]           in_order_id,
  input  logic [proot_pkg::INST_W-1:0]         in_instrument,
  input  logic                                 in_side,
  input  logic signed [proot_pkg::PRICE_W-1:0] in_price,
  input  logic [proot_pkg::VOL_W-1:0]          in_volume,
  input  logic [proot_pkg::VOL_W-1:0]          in_second_volume,
  input  logic                                 in_fill_done,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_verdict,
  output logic [CW-1:0]                        out_open_orders
);

  localparam int SAW  = $clog2(SLOT_COUNT);
  localparam int IAW  = (INSTRUMENT_COUNT > 1) ? $clog2(INSTRUMENT_COUNT) : 1;
  localparam int MAXD = (SLOT_COUNT > INSTRUMENT_COUNT) ? SLOT_COUNT : INSTRUMENT_COUNT;
  localparam int CLRW = $clog2(MAXD);

  typedef struct packed {
    logic                                 used;
    logic [proot_pkg::ID_W-1:0]           id;
    logic [IAW-1:0]                       inst;
    logic                                 side;
    logic signed [proot_pkg::PRICE_W-1:0] price;
    logic signed [proot_pkg::REM_W-1:0]   rem;
  } slot_t;

  typedef struct packed {
    logic [CW-1:0]                        bid_cnt;
    logic [CW-1:0]                        ask_cnt;
    logic signed [proot_pkg::PRICE_W-1:0] top_bid;
    logic signed [proot_pkg::PRICE_W-1:0] top_ask;
  } inst_t;

  typedef enum logic [12:0] {
    ST_CLEAR  = 13'b0000000000001,
    ST_IDLE   = 13'b0000000000010,
    ST_DECODE = 13'b0000000000100,
    ST_CHKRD  = 13'b0000000001000,
    ST_FIND   = 13'b0000000010000,
    ST_FOUND  = 13'b0000000100000,
    ST_REM    = 13'b0000001000000,
    ST_REMRD  = 13'b0000010000000,
    ST_RESCAN = 13'b0000100000000,
    ST_AFTER  = 13'b0001000000000,
    ST_POP    = 13'b0010000000000,
    ST_POPRD  = 13'b0100000000000,
    ST_DONE   = 13'b1000000000000
  } state_t;

  // Memories.
  slot_t          slot_mem [SLOT_COUNT];
  logic [SAW-1:0] free_mem [SLOT_COUNT];
  inst_t          inst_mem [INSTRUMENT_COUNT];

  slot_t          slot_q, slot_wdata;
  logic [SAW-1:0] slot_raddr, slot_waddr;
  logic           slot_we;
  logic [SAW-1:0] free_q, free_raddr, free_waddr, free_wdata;
  logic           free_we;
  inst_t          inst_q, inst_wdata;
  logic [IAW-1:0] inst_raddr, inst_waddr;
  logic           inst_we;

  // Control and captured word.
  state_t state_r, state_nxt;
  logic [2:0]                           act_r, act_nxt;
  logic [proot_pkg::ID_W-1:0]           id_r, id_nxt;
  logic [proot_pkg::INST_W-1:0]         inst_r, inst_nxt;
  logic                                 side_r, side_nxt;
  logic signed [proot_pkg::PRICE_W-1:0] price_r, price_nxt;
  logic [proot_pkg::VOL_W-1:0]          vol_r, vol_nxt, vol2_r, vol2_nxt;
  logic                                 full_r, full_nxt;
  logic [proot_pkg::VOL_W-1:0]          max_r, max_nxt;
  logic [1:0]                           verdict_r, verdict_nxt;
  logic [CW-1:0]                        open_r, open_nxt, free_cnt_r, free_cnt_nxt;
  logic [CLRW-1:0]                      clr_r, clr_nxt;
  logic [CW-1:0]                        scan_cnt_r, scan_cnt_nxt;
  logic                                 pend_r, pend_nxt;
  logic [SAW-1:0]                       fslot_r, fslot_nxt;
  slot_t                                fent_r, fent_nxt;
  inst_t                                ient_r, ient_nxt;
  logic [CW-1:0]                        rs_n_r, rs_n_nxt;
  logic signed [proot_pkg::PRICE_W-1:0] rs_best_r, rs_best_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [1:0]                           out_verdict_r, out_verdict_nxt;
  logic [CW-1:0]                        out_open_r, out_open_nxt;

  // Helpers.
  logic                                 inst_ok, id_hit, rs_hit, rs_better, scan_end;
  logic [CW-1:0]                        rs_n_new, side_cnt, side_dec;
  logic signed [proot_pkg::PRICE_W-1:0] rs_best_new, side_best;
  logic signed [proot_pkg::REM_W-1:0]   rem_new;
  inst_t                                ient_upd;

  // Synchronous memory ports.
  always_ff @(posedge clk) begin
    slot_q <= slot_mem[slot_raddr];
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
  end

  always_ff @(posedge clk) begin
    free_q <= free_mem[free_raddr];
    if (free_we) begin
      free_mem[free_waddr] <= free_wdata;
    end
  end

  always_ff @(posedge clk) begin
    inst_q <= inst_mem[inst_raddr];
    if (inst_we) begin
      inst_mem[inst_waddr] <= inst_wdata;
    end
  end

  // Pipelined scan terms: the slot read issued in the previous cycle is checked in this one.
  assign inst_ok   = inst_r < proot_pkg::INST_W'(INSTRUMENT_COUNT);
  assign id_hit    = pend_r && slot_q.used && (slot_q.id == id_r);
  assign scan_end  = scan_cnt_r == CW'(SLOT_COUNT);
  assign rs_hit    = pend_r && slot_q.used && (slot_q.inst == fent_r.inst) &&
                     (slot_q.side == fent_r.side);
  assign rs_better = fent_r.side ? (slot_q.price < rs_best_r) : (slot_q.price > rs_best_r);
  assign rs_n_new  = rs_n_r + CW'(rs_hit);
  assign rs_best_new = (rs_hit && ((rs_n_r == '0) || rs_better)) ? slot_q.price : rs_best_r;
  assign rem_new   = fent_r.rem - $signed({2'b00, vol_r});
  assign side_cnt  = fent_r.side ? inst_q.ask_cnt : inst_q.bid_cnt;
  assign side_best = fent_r.side ? inst_q.top_ask : inst_q.top_bid;
  assign side_dec  = (side_cnt != '0) ? side_cnt - CW'(1) : '0;

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    id_nxt       = id_r;
    inst_nxt     = inst_r;
    side_nxt     = side_r;
    price_nxt    = price_r;
    vol_nxt      = vol_r;
    vol2_nxt     = vol2_r;
    full_nxt     = full_r;
    max_nxt      = cfg_wr_en ? cfg_wr_data : max_r;
    verdict_nxt  = verdict_r;
    open_nxt     = open_r;
    free_cnt_nxt = free_cnt_r;
    clr_nxt      = clr_r;
    scan_cnt_nxt = scan_cnt_r;
    pend_nxt     = 1'b0;
    fslot_nxt    = fslot_r;
    fent_nxt     = fent_r;
    ient_nxt     = ient_r;
    rs_n_nxt     = rs_n_r;
    rs_best_nxt  = rs_best_r;
    ient_upd     = inst_q;

    slot_raddr = scan_cnt_r[SAW-1:0];
    slot_we    = 1'b0;
    slot_waddr = fslot_r;
    slot_wdata = fent_r;
    free_raddr = free_cnt_r[SAW-1:0] - SAW'(1);
    free_we    = 1'b0;
    free_waddr = free_cnt_r[SAW-1:0];
    free_wdata = fslot_r;
    inst_raddr = inst_r[IAW-1:0];
    inst_we    = 1'b0;
    inst_waddr = fent_r.inst;
    inst_wdata = ient_r;

    // A finished result leaves the output register when it is taken.
    out_valid_nxt   = out_valid_r && out_stall;
    out_verdict_nxt = out_verdict_r;
    out_open_nxt    = out_open_r;

    case (state_r)
      ST_CLEAR: begin
        // One entry of each memory a cycle.
        slot_waddr = clr_r[SAW-1:0];
        slot_wdata = '0;
        slot_we    = {1'b0, clr_r} < (CLRW + 1)'(SLOT_COUNT);
        free_waddr = clr_r[SAW-1:0];
        free_wdata = SAW'(SLOT_COUNT - 1) - clr_r[SAW-1:0];
        free_we    = slot_we;
        inst_waddr = clr_r[IAW-1:0];
        inst_wdata = '0;
        inst_we    = {1'b0, clr_r} < (CLRW + 1)'(INSTRUMENT_COUNT);
        clr_nxt    = clr_r + CLRW'(1);
        if (clr_r == CLRW'(MAXD - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          act_nxt     = in_action;
          id_nxt      = in_order_id;
          inst_nxt    = in_instrument;
          side_nxt    = in_side;
          price_nxt   = in_price;
          vol_nxt     = in_volume;
          vol2_nxt    = in_second_volume;
          full_nxt    = in_fill_done;
          verdict_nxt = proot_pkg::VERDICT_OK;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        scan_cnt_nxt = '0;
        case (act_r)
          proot_pkg::ACT_CHECK_ORDER: begin
            if (vol_r > max_r) begin
              verdict_nxt = proot_pkg::VERDICT_MAX_VOL;
              state_nxt   = ST_DONE;
            end else if (open_r >= CW'(SLOT_COUNT)) begin
              verdict_nxt = proot_pkg::VERDICT_TOO_MANY;
              state_nxt   = ST_DONE;
            end else if (inst_ok) begin
              state_nxt = ST_CHKRD;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          proot_pkg::ACT_CHECK_QUOTE: begin
            if ((vol_r > max_r) || (vol2_r > max_r)) begin
              verdict_nxt = proot_pkg::VERDICT_MAX_VOL;
            end
            state_nxt = ST_DONE;
          end
          proot_pkg::ACT_ACK: begin
            state_nxt = ((id_r == '0) || !inst_ok) ? ST_DONE : ST_FIND;
          end
          proot_pkg::ACT_FILL, proot_pkg::ACT_CANCEL: begin
            state_nxt = ST_FIND;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_CHKRD: begin
        // Would this order cross an own resting order on the other side?
        if (!side_r) begin
          if ((inst_q.ask_cnt != '0) && (inst_q.top_ask <= price_r)) begin
            verdict_nxt = proot_pkg::VERDICT_SELF_TRADE;
          end
        end else begin
          if ((inst_q.bid_cnt != '0) && (inst_q.top_bid >= price_r)) begin
            verdict_nxt = proot_pkg::VERDICT_SELF_TRADE;
          end
        end
        state_nxt = ST_DONE;
      end
      ST_FIND: begin
        // Walk the slots one a cycle until the id turns up.
        if (id_hit) begin
          fslot_nxt = fslot_r;
          fent_nxt  = slot_q;
          state_nxt = ST_FOUND;
        end else if (scan_end) begin
          state_nxt = (act_r == proot_pkg::ACT_ACK) ? ST_POP : ST_DONE;
        end else begin
          pend_nxt     = 1'b1;
          fslot_nxt    = scan_cnt_r[SAW-1:0];
          scan_cnt_nxt = scan_cnt_r + CW'(1);
        end
      end
      ST_FOUND: begin
        if ((act_r == proot_pkg::ACT_FILL) && !full_r && (rem_new > 0)) begin
          slot_we        = 1'b1;
          slot_wdata     = fent_r;
          slot_wdata.rem = rem_new;
          state_nxt      = ST_DONE;
        end else begin
          state_nxt = ST_REM;
        end
      end
      ST_REM: begin
        // Free the slot and fetch its instrument entry.
        slot_we         = 1'b1;
        slot_wdata      = fent_r;
        slot_wdata.used = 1'b0;
        if (free_cnt_r < CW'(SLOT_COUNT)) begin
          free_we      = 1'b1;
          free_cnt_nxt = free_cnt_r + CW'(1);
        end
        if (open_r != '0) begin
          open_nxt = open_r - CW'(1);
        end
        inst_raddr = fent_r.inst;
        state_nxt  = ST_REMRD;
      end
      ST_REMRD: begin
        ient_nxt     = inst_q;
        scan_cnt_nxt = '0;
        rs_n_nxt     = '0;
        rs_best_nxt  = '0;
        if (fent_r.side) begin
          ient_upd.ask_cnt = side_dec;
          if (side_dec == '0) ient_upd.top_ask = '0;
        end else begin
          ient_upd.bid_cnt = side_dec;
          if (side_dec == '0) ient_upd.top_bid = '0;
        end
        if ((side_dec != '0) &&
            (fent_r.side ? (fent_r.price <= side_best) : (fent_r.price >= side_best))) begin
          state_nxt = ST_RESCAN;
        end else begin
          inst_we    = 1'b1;
          inst_wdata = ient_upd;
          state_nxt  = ST_AFTER;
        end
      end
      ST_RESCAN: begin
        // Rebuild count and best price of this side over all used slots.
        rs_n_nxt    = rs_n_new;
        rs_best_nxt = rs_best_new;
        if (scan_end) begin
          inst_we    = 1'b1;
          inst_wdata = ient_r;
          if (fent_r.side) begin
            inst_wdata.ask_cnt = rs_n_new;
            inst_wdata.top_ask = rs_best_new;
          end else begin
            inst_wdata.bid_cnt = rs_n_new;
            inst_wdata.top_bid = rs_best_new;
          end
          state_nxt = ST_AFTER;
        end else begin
          pend_nxt     = 1'b1;
          scan_cnt_nxt = scan_cnt_r + CW'(1);
        end
      end
      ST_AFTER: begin
        state_nxt = (act_r == proot_pkg::ACT_ACK) ? ST_POP : ST_DONE;
      end
      ST_POP: begin
        if (free_cnt_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          free_cnt_nxt = free_cnt_r - CW'(1);
          state_nxt    = ST_POPRD;
        end
      end
      ST_POPRD: begin
        // Place the acked order and fold it into its instrument.
        slot_we          = 1'b1;
        slot_waddr       = free_q;
        slot_wdata.used  = 1'b1;
        slot_wdata.id    = id_r;
        slot_wdata.inst  = inst_r[IAW-1:0];
        slot_wdata.side  = side_r;
        slot_wdata.price = price_r;
        slot_wdata.rem   = $signed({2'b00, vol_r});
        inst_we          = 1'b1;
        inst_waddr       = inst_r[IAW-1:0];
        if (side_r) begin
          ient_upd.ask_cnt = inst_q.ask_cnt + CW'(1);
          if ((inst_q.ask_cnt == '0) || (price_r < inst_q.top_ask)) begin
            ient_upd.top_ask = price_r;
          end
        end else begin
          ient_upd.bid_cnt = inst_q.bid_cnt + CW'(1);
          if ((inst_q.bid_cnt == '0) || (price_r > inst_q.top_bid)) begin
            ient_upd.top_bid = price_r;
          end
        end
        inst_wdata = ient_upd;
        open_nxt   = open_r + CW'(1);
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = verdict_r;
          out_open_nxt    = open_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      max_r       <= '0;
      open_r      <= '0;
      free_cnt_r  <= CW'(SLOT_COUNT);
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      max_r       <= max_nxt;
      open_r      <= open_nxt;
      free_cnt_r  <= free_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    act_r         <= act_nxt;
    id_r          <= id_nxt;
    inst_r        <= inst_nxt;
    side_r        <= side_nxt;
    price_r       <= price_nxt;
    vol_r         <= vol_nxt;
    vol2_r        <= vol2_nxt;
    full_r        <= full_nxt;
    verdict_r     <= verdict_nxt;
    scan_cnt_r    <= scan_cnt_nxt;
    fslot_r       <= fslot_nxt;
    fent_r        <= fent_nxt;
    ient_r        <= ient_nxt;
    rs_n_r        <= rs_n_nxt;
    rs_best_r     <= rs_best_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_open_r    <= out_open_nxt;
  end

  assign in_stall        = state_r != ST_IDLE;
  assign out_valid       = out_valid_r;
  assign out_verdict     = out_verdict_r;
  assign out_open_orders = out_open_r;

endmodule

FILE: bench/pretrade_risk_open_order_table_tb.sv
// Self-checking bench for the pre-trade risk open-order table.
// Drives checks, acks, fills and cancels against an internal predictor; depends on
// proot_pkg and pretrade_risk_open_order_table.
`timescale 1ns / 100ps

module pretrade_risk_open_order_table_tb;

  localparam int SLOTS = proot_pkg::SLOT_COUNT_DEF;
  localparam int INSTS = proot_pkg::INST_COUNT_DEF;
  localparam int VW = proot_pkg::VOL_W;
  localparam int TAIL_CYCLES = 2 * SLOTS + 20;

  typedef struct {
    logic [2:0]                      action;
    logic [proot_pkg::ID_W-1:0]      order_id;
    logic [proot_pkg::INST_W-1:0]    instrument;
    logic                            side;
    logic signed [31:0]              price;
    logic [VW-1:0]                   volume;
    logic [VW-1:0]                   second_volume;
    logic                            fill_done;
  } order_word_t;

  typedef struct {
    logic [1:0] verdict;
    logic [8:0] open_orders;
  } risk_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [VW-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_action = '0;
  logic [proot_pkg::ID_W-1:0] in_order_id = '0;
  logic [proot_pkg::INST_W-1:0] in_instrument = '0;
  logic in_side = 1'b0;
  logic signed [31:0] in_price = '0;
  logic [VW-1:0] in_volume = '0;
  logic [VW-1:0] in_second_volume = '0;
  logic in_fill_done = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_verdict;
  logic [8:0] out_open_orders;

  order_word_t  pending_words[$];
  risk_result_t expected_results[$];
  int fail_count = 0;
  bit hold_sender = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  // Predictor state.
  logic [VW-1:0]      vol_limit;
  bit                 p_used[SLOTS];
  logic [31:0]        p_id[SLOTS];
  logic [15:0]        p_inst[SLOTS];
  bit                 p_side[SLOTS];
  logic signed [31:0] p_price[SLOTS];
  logic signed [33:0] p_remain[SLOTS];
  int                 free_list[SLOTS];
  int                 free_n, open_n;
  int                 bid_n[INSTS], ask_n[INSTS];
  logic signed [31:0] top_bid[INSTS], top_ask[INSTS];

  // Pool of ids that the random part reuses so fills and cancels hit.
  logic [31:0] live_ids[$];

  pretrade_risk_open_order_table dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_order_id(in_order_id),
    .in_instrument(in_instrument), .in_side(in_side),
    .in_price(in_price), .in_volume(in_volume),
    .in_second_volume(in_second_volume), .in_fill_done(in_fill_done),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_verdict(out_verdict), .out_open_orders(out_open_orders)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic void book_reset();
    vol_limit = '0;
    for (int i = 0; i < SLOTS; i++) begin
      p_used[i] = 1'b0;
      free_list[i] = SLOTS - 1 - i;
    end
    free_n = SLOTS;
    open_n = 0;
    for (int i = 0; i < INSTS; i++) begin
      bid_n[i] = 0; ask_n[i] = 0; top_bid[i] = 0; top_ask[i] = 0;
    end
  endfunction

  function automatic int locate_order(logic [31:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (p_used[i] && p_id[i] == id) return i;
    return -1;
  endfunction

  // Rebuild the count and best price of one side of one instrument.
  function automatic void rebuild_side(int inst, bit sd);
    int n;
    logic signed [31:0] best;
    n = 0;
    best = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!p_used[i] || p_inst[i] != inst || p_side[i] != sd) continue;
      n++;
      if (n == 1 || (sd == 1'b0 ? p_price[i] > best : p_price[i] < best)) best = p_price[i];
    end
    if (sd == 1'b0) begin
      bid_n[inst] = n; top_bid[inst] = best;
    end else begin
      ask_n[inst] = n; top_ask[inst] = best;
    end
  endfunction

  function automatic void drop_order(int s);
    int inst;
    if (s < 0 || !p_used[s]) return;
    p_used[s] = 1'b0;
    inst = int'(p_inst[s]);
    if (p_side[s] == 1'b0) begin
      if (bid_n[inst] > 0) bid_n[inst]--;
      if (bid_n[inst] == 0) top_bid[inst] = 0;
      else if (p_price[s] >= top_bid[inst]) rebuild_side(inst, 1'b0);
    end else begin
      if (ask_n[inst] > 0) ask_n[inst]--;
      if (ask_n[inst] == 0) top_ask[inst] = 0;
      else if (p_price[s] <= top_ask[inst]) rebuild_side(inst, 1'b1);
    end
    if (free_n < SLOTS) free_list[free_n++] = s;
    if (open_n > 0) open_n--;
  endfunction

  // Apply one word to the book and return the risk result it yields.
  function automatic risk_result_t apply_word(order_word_t w);
    risk_result_t r;
    int s, inst;
    r.verdict = proot_pkg::VERDICT_OK;
    inst = int'(w.instrument);
    case (w.action)
      proot_pkg::ACT_CHECK_ORDER: begin
        if (w.volume > vol_limit) r.verdict = proot_pkg::VERDICT_MAX_VOL;
        else if (open_n >= SLOTS) r.verdict = proot_pkg::VERDICT_TOO_MANY;
        else if (inst < INSTS) begin
          if (w.side == 1'b0 && ask_n[inst] > 0 && top_ask[inst] <= w.price)
            r.verdict = proot_pkg::VERDICT_SELF_TRADE;
          if (w.side == 1'b1 && bid_n[inst] > 0 && top_bid[inst] >= w.price)
            r.verdict = proot_pkg::VERDICT_SELF_TRADE;
        end
      end
      proot_pkg::ACT_CHECK_QUOTE: begin
        if (w.volume > vol_limit || w.second_volume > vol_limit)
          r.verdict = proot_pkg::VERDICT_MAX_VOL;
      end
      proot_pkg::ACT_ACK: begin
        if (w.order_id != 0 && inst < INSTS) begin
          drop_order(locate_order(w.order_id));
          if (free_n > 0) begin
            free_n--;
            s = free_list[free_n];
            p_id[s] = w.order_id;
            p_inst[s] = 16'(inst);
            p_side[s] = w.side;
            p_price[s] = w.price;
            p_remain[s] = {3'b000, w.volume};
            p_used[s] = 1'b1;
            if (w.side == 1'b0) begin
              bid_n[inst]++;
              if (bid_n[inst] == 1 || w.price > top_bid[inst]) top_bid[inst] = w.price;
            end else begin
              ask_n[inst]++;
              if (ask_n[inst] == 1 || w.price < top_ask[inst]) top_ask[inst] = w.price;
            end
            open_n++;
          end
        end
      end
      proot_pkg::ACT_FILL: begin
        s = locate_order(w.order_id);
        if (s >= 0) begin
          p_remain[s] = p_remain[s] - $signed({3'b000, w.volume});
          if (w.fill_done || p_remain[s] <= 0) drop_order(s);
        end
      end
      proot_pkg::ACT_CANCEL: drop_order(locate_order(w.order_id));
      default: ;
    endcase
    r.open_orders = open_n[8:0];
    return r;
  endfunction

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random price near a small band so crosses are common, sometimes an extreme.
  function automatic logic signed [31:0] pick_price();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 32'sh7fffffff;
    if (roll == 1) return 32'sh80000000;
    if (roll == 2) return $urandom();
    return $signed($urandom_range(0, 40)) - 20;
  endfunction

  function automatic logic [VW-1:0] pick_volume();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return {VW{1'b1}};
    if (roll == 1) return VW'($urandom());
    return VW'($urandom_range(0, 200));
  endfunction

  function automatic order_word_t make_word(logic [2:0] act, logic [31:0] id,
                                            logic [15:0] inst, bit sd,
                                            logic signed [31:0] pr, logic [VW-1:0] v,
                                            logic [VW-1:0] v2, bit full);
    order_word_t w;
    w.action = act; w.order_id = id; w.instrument = inst; w.side = sd;
    w.price = pr; w.volume = v; w.second_volume = v2; w.fill_done = full;
    return w;
  endfunction

  function automatic order_word_t random_word();
    int roll;
    logic [31:0] id;
    logic [15:0] inst;
    roll = $urandom_range(0, 99);
    if (live_ids.size() > 0 && $urandom_range(0, 3) != 0)
      id = live_ids[$urandom_range(0, live_ids.size() - 1)];
    else
      id = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom();
    inst = ($urandom_range(0, 24) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 7));
    if ($urandom_range(0, 30) == 0) inst = 16'($urandom_range(0, INSTS - 1));
    if (roll < 35) begin
      if (live_ids.size() < 300) live_ids.push_back(id);
      return make_word(proot_pkg::ACT_ACK, id, inst, 1'($urandom()), pick_price(),
                       pick_volume(), VW'($urandom()), 1'($urandom()));
    end
    if (roll < 60)
      return make_word(proot_pkg::ACT_CHECK_ORDER, $urandom(), inst, 1'($urandom()),
                       pick_price(), pick_volume(), VW'($urandom()), 1'($urandom()));
    if (roll < 68)
      return make_word(proot_pkg::ACT_CHECK_QUOTE, $urandom(), inst, 1'($urandom()),
                       $urandom(), pick_volume(), pick_volume(), 1'($urandom()));
    if (roll < 84)
      return make_word(proot_pkg::ACT_FILL, id, inst, 1'($urandom()), $urandom(),
                       pick_volume(), VW'($urandom()), $urandom_range(0, 3) == 0);
    if (roll < 97)
      return make_word(proot_pkg::ACT_CANCEL, id, inst, 1'($urandom()), $urandom(),
                       VW'($urandom()), VW'($urandom()), 1'($urandom()));
    return make_word(3'($urandom_range(5, 7)), $urandom(), 16'($urandom()), 1'($urandom()),
                     $urandom(), VW'($urandom()), VW'($urandom()), 1'($urandom()));
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [VW-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    vol_limit = value;
  endtask

  // Driver: each word is predicted at the edge it is accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_word('{in_action, in_order_id, in_instrument,
            in_side, in_price, in_volume, in_second_volume, in_fill_done}));
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0 && !hold_sender) begin
          order_word_t w;
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          in_action <= w.action;
          in_order_id <= w.order_id;
          in_instrument <= w.instrument;
          in_side <= w.side;
          in_price <= w.price;
          in_volume <= w.volume;
          in_second_volume <= w.second_volume;
          in_fill_done <= w.fill_done;
          send_gap <= gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          risk_result_t e;
          e = expected_results.pop_front();
          if (out_verdict !== e.verdict) begin
            $error("verdict: expected %0d, got %0d", e.verdict, out_verdict);
            fail_count++;
          end
          if (out_open_orders !== e.open_orders) begin
            $error("open_orders: expected %0d, got %0d", e.open_orders, out_open_orders);
            fail_count++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        recv_gap <= gap_len();
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    book_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Zero limit: everything but a zero volume is oversize.
    pending_words.push_back(make_word(proot_pkg::ACT_CHECK_ORDER, 1, 0, 0, 0, 1, 0, 0));
    pending_words.push_back(make_word(proot_pkg::ACT_CHECK_QUOTE, 1, 0, 0, 0, 0, 0, 0));
    wait_drained();

    write_limit({VW{1'b1}});
    pending_words.push_back(make_word(proot_pkg::ACT_ACK, 32'hffff_ffff, 0, 0, 32'sh7fffffff,
                                      {VW{1'b1}}, 0, 0));
    pending_words.push_back(make_word(proot_pkg::ACT_ACK, 2, 0, 1, 32'sh80000000, 0, 0, 0));
    pending_words.push_back(make_word(proot_pkg::ACT_ACK, 0, 1, 0, 5, 5, 0, 0));
    pending_words.push_back(make_word(proot_pkg::ACT_ACK, 3, 16'hffff, 0, 5, 5, 0, 0));
    pending_words.push_back(make_word(proot_pkg::ACT_ACK, 4, 63, 0, 10, 5, 0, 0));
    pending_words.push_back(make_word(proot_pkg::ACT_CHECK_ORDER, 9, 0, 0, 32'sh80000000,
                                      7, 0, 0));
    pending_words.push_back(make_word(proot_pkg::ACT_CHECK_ORDER, 9, 0, 1, 32'sh7fffffff,
                                      7, 0, 0));
    pending_words.push_back(make_word(proot_pkg::ACT_CHECK_ORDER, 9, 63, 1, 11, 7, 0, 0));
    pending_words.push_back(make_word(proot_pkg::ACT_CHECK_ORDER, 9, 63, 1, 10, 7, 0, 0));
    pending_words.push_back(make_word(proot_pkg::ACT_CHECK_ORDER, 9, 16'hffff, 1, 0, 7, 0, 0));
    pending_words.push_back(make_word(proot_pkg::ACT_CHECK_QUOTE, 9, 0, 0, 0, {VW{1'b1}},
                                      {VW{1'b1}}, 1));
    pending_words.push_back(make_word(proot_pkg::ACT_ACK, 4, 63, 1, 3, 5, 0, 0));
    pending_words.push_back(make_word(proot_pkg::ACT_FILL, 4, 0, 0, 0, 2, 0, 0));
    pending_words.push_back(make_word(proot_pkg::ACT_FILL, 4, 0, 0, 0, 3, 0, 0));
    pending_words.push_back(make_word(proot_pkg::ACT_FILL, 32'hffff_ffff, 0, 0, 0, 0, 0, 1));
    pending_words.push_back(make_word(proot_pkg::ACT_FILL, 0, 0, 0, 0, 0, 0, 1));
    pending_words.push_back(make_word(proot_pkg::ACT_CANCEL, 77, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(proot_pkg::ACT_CANCEL, 2, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(3'd5, 1, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(3'd7, 1, 0, 0, 0, 0, 0, 0));
    wait_drained();

    // Fill the table to the brim, then probe the full case and drain part of it.
    write_limit(31'd100);
    for (int i = 0; i < SLOTS + 2; i++)
      pending_words.push_back(make_word(proot_pkg::ACT_ACK, 32'h1000 + i, 16'(i % 8), i[0],
                                        $signed(i % 30) - 15, 31'(i % 90), 0, 0));
    pending_words.push_back(make_word(proot_pkg::ACT_CHECK_ORDER, 1, 0, 0, 0, 100, 0, 0));
    pending_words.push_back(make_word(proot_pkg::ACT_CHECK_ORDER, 1, 0, 0, 0, 101, 0, 0));
    pending_words.push_back(make_word(proot_pkg::ACT_ACK, 32'h1005, 3, 0, 9, 9, 0, 0));
    for (int i = 0; i < SLOTS; i += 2)
      pending_words.push_back(make_word(proot_pkg::ACT_CANCEL, 32'h1000 + i, 0, 0, 0, 0, 0, 0));
    for (int i = 1; i < SLOTS; i += 4)
      live_ids.push_back(32'h1000 + i);

    // Random part under several limits, with one full pause of the sender.
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: write_limit(31'd150);
        1: write_limit(31'd0);
        2: write_limit({VW{1'b1}});
        default: write_limit(31'd60);
      endcase
      for (int i = 0; i < 110; i++) begin
        if (phase == 2 && i == 55) begin
          wait (pending_words.size() == 0);
          hold_sender = 1'b1;
          wait (expected_results.size() == 0 && !in_valid);
          hold_sender = 1'b0;
        end
        pending_words.push_back(random_word());
        if (pending_words.size() > 8) wait (pending_words.size() <= 4);
      end
    end
    wait_drained();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
